// File: hdl/ddrc_pkg.sv
// shared types and constants of the differential drive ramp controller
package ddrc_pkg;

  localparam int LEVEL_COUNT_DEF = 50;

  localparam logic [7:0]  MAX_DRIVE_RST     = 8'd70;
  localparam logic [7:0]  MIN_DRIVE_RST     = 8'd50;
  localparam logic [7:0]  STOP_STEP_RST     = 8'd10;
  localparam logic [14:0] CLEAR_ECHO_US_RST = 15'd1167;

  typedef enum logic [2:0] {
    DIR_STOP  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_BACK  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_IGNORED  = 3'd1,
    ST_BLOCKED  = 3'd2,
    ST_REVERSAL = 3'd3,
    ST_RAMPED   = 3'd4,
    ST_ABORT    = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_MAX_DRIVE     = 2'd0,
    REG_MIN_DRIVE     = 2'd1,
    REG_STOP_STEP     = 2'd2,
    REG_CLEAR_ECHO_US = 2'd3
  } reg_idx_t;

  typedef enum logic {
    OP_COMMAND = 1'b0,
    OP_TICK    = 1'b1
  } opcode_t;

  function automatic logic is_opposite(input logic [2:0] a, input logic [2:0] b);
    is_opposite = (a == DIR_FWD   && b == DIR_BACK)  || (a == DIR_BACK  && b == DIR_FWD) ||
                  (a == DIR_LEFT  && b == DIR_RIGHT) || (a == DIR_RIGHT && b == DIR_LEFT);
  endfunction

endpackage

// File: hdl/differential_drive_ramp_controller.sv
// top level of the differential drive ramp controller
//
// soft-start drive controller for the two motors of a differential drive.
// input stream: s_tuser carries the opcode (0 direction command, 1 ramp tick),
// s_tdata carries the direction and the two echo times. every input item
// yields exactly one result item on the m_ stream: status, signed left and
// right drive now applied, and the speed level after the item.
// registers sit behind a small apb-style port (max_drive, min_drive,
// stop_step, clear_echo_us at byte addresses 0, 4, 8, 12); write them only
// while no item is in flight.
// the block is a four-register pipeline: input register, product stage,
// reciprocal divide stage, output register. a result shows up on m_tvalid
// in the output register; one item can be taken every cycle while m_tready
// is high. direction, level and stopping state update in the first stage so
// the next item sees them at once; the drive mapping trails behind.
// each stage holds its item when the next one is full, so a stalled m_tready
// still lets items fill the empty stages before s_tready drops.
// synchronous reset clears all direction, level and drive state, empties the
// pipeline and restores the register defaults.
module differential_drive_ramp_controller
  import ddrc_pkg::*;
#(
  parameter int LEVEL_COUNT = LEVEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // direction[2:0], left_echo_us[17:3], right_echo_us[32:18]
  input  logic [0:0]  s_tuser,   // opcode[0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // status[2:0], left_drive[11:3], right_drive[20:12],
                                 // level_now[28:21]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // level mapping divisor and its reciprocal, exact for products below 2**16
  localparam int            DIV      = LEVEL_COUNT - 1;
  localparam int            SHIFT    = 24;
  localparam logic [24:0]   RECIP    = 25'(((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV));
  localparam logic [7:0]    GOAL_FULL = 8'(LEVEL_COUNT);
  localparam logic [7:0]    GOAL_TURN = 8'(LEVEL_COUNT / 2);
  localparam logic [15:0]   DIV16    = 16'(DIV);

  // configuration registers
  logic [7:0]  max_drive;
  logic [7:0]  min_drive;
  logic [7:0]  stop_step;
  logic [14:0] clear_echo_us;

  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_drive     <= MAX_DRIVE_RST;
      min_drive     <= MIN_DRIVE_RST;
      stop_step     <= STOP_STEP_RST;
      clear_echo_us <= CLEAR_ECHO_US_RST;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_MAX_DRIVE:     max_drive     <= pwdata[7:0];
        REG_MIN_DRIVE:     min_drive     <= pwdata[7:0];
        REG_STOP_STEP:     stop_step     <= pwdata[7:0];
        REG_CLEAR_ECHO_US: clear_echo_us <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_MAX_DRIVE:     prdata = {24'd0, max_drive};
      REG_MIN_DRIVE:     prdata = {24'd0, min_drive};
      REG_STOP_STEP:     prdata = {24'd0, stop_step};
      REG_CLEAR_ECHO_US: prdata = {17'd0, clear_echo_us};
      default:           prdata = 32'd0;
    endcase
  end

  // per-stage valid bits and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4      = !v4 || m_tready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1 && !rst;
  assign m_tvalid = v4;

  // stage 1: input register
  logic        s1_tick;
  logic [2:0]  s1_dir;
  logic [14:0] s1_left_echo;
  logic [14:0] s1_right_echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && s_tvalid) begin
      s1_tick       <= (opcode_t'(s_tuser[0]) == OP_TICK);
      s1_dir        <= s_tdata[2:0];
      s1_left_echo  <= s_tdata[17:3];
      s1_right_echo <= s_tdata[32:18];
    end
  end

  // control state
  dir_t       target_dir, target_dir_next;
  dir_t       moving_dir, moving_dir_next;
  logic [7:0] speed_level, speed_level_next;
  logic       stopping, stopping_next;

  status_t    status1;
  logic       upd1;       // tick that rewrites the held drives
  logic       zero1;      // mapped drive is zero at the new level
  logic       path_clear;
  logic [7:0] goal;
  logic [7:0] lvl_m1;
  logic [15:0] zero_prod;

  always_comb begin
    path_clear = (s1_left_echo == 15'd0 || s1_left_echo >= clear_echo_us) &&
                 (s1_right_echo == 15'd0 || s1_right_echo >= clear_echo_us);
    target_dir_next  = target_dir;
    moving_dir_next  = moving_dir;
    speed_level_next = speed_level;
    stopping_next    = stopping;
    status1          = ST_IGNORED;
    upd1             = 1'b0;
    goal             = 8'd0;
    lvl_m1           = 8'd0;
    zero_prod        = 16'd0;
    zero1            = 1'b1;

    if (!s1_tick) begin
      if (s1_dir > DIR_RIGHT || s1_dir == target_dir) begin
        status1 = ST_IGNORED;
      end else if (s1_dir == DIR_FWD && !path_clear) begin
        status1 = ST_BLOCKED;
      end else if (is_opposite(s1_dir, target_dir)) begin
        target_dir_next = DIR_STOP;
        stopping_next   = 1'b1;
        status1         = ST_REVERSAL;
      end else begin
        if (s1_dir == DIR_STOP) begin
          stopping_next = 1'b1;
        end else begin
          moving_dir_next = dir_t'(s1_dir);
          stopping_next   = 1'b0;
        end
        target_dir_next = dir_t'(s1_dir);
        status1         = ST_ACCEPTED;
      end
    end else if (target_dir == DIR_FWD && !path_clear) begin
      // obstacle ahead: abort to a stop, drives untouched
      target_dir_next = DIR_STOP;
      stopping_next   = 1'b1;
      status1         = ST_ABORT;
    end else begin
      case (target_dir)
        DIR_STOP:             goal = 8'd0;
        DIR_LEFT, DIR_RIGHT:  goal = GOAL_TURN;
        default:              goal = GOAL_FULL;
      endcase
      if (speed_level < goal) begin
        speed_level_next = speed_level + 8'd1;
        stopping_next    = 1'b0;
      end else if (speed_level > goal) begin
        if (target_dir == DIR_STOP && stopping) begin
          speed_level_next = (speed_level > stop_step) ? speed_level - stop_step : 8'd0;
        end else begin
          speed_level_next = speed_level - 8'd1;
        end
      end
      // drive is zero at level zero, with min_drive zero below one step,
      // or with max_drive zero at the top level
      lvl_m1    = speed_level_next - 8'd1;
      zero_prod = {8'd0, lvl_m1} * {8'd0, max_drive};
      zero1     = (speed_level_next == 8'd0) ||
                  (min_drive == 8'd0 && zero_prod < DIV16) ||
                  (max_drive == 8'd0 && speed_level_next == GOAL_FULL);
      if (zero1 && target_dir == DIR_STOP) begin
        moving_dir_next = DIR_STOP;
        stopping_next   = 1'b0;
      end
      upd1    = 1'b1;
      status1 = ST_RAMPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_dir  <= DIR_STOP;
      moving_dir  <= DIR_STOP;
      speed_level <= 8'd0;
      stopping    <= 1'b0;
    end else if (v1 && en2) begin
      target_dir  <= target_dir_next;
      moving_dir  <= moving_dir_next;
      speed_level <= speed_level_next;
      stopping    <= stopping_next;
    end
  end

  // stage 2: (level - 1) * |max - min|
  status_t    s2_status;
  logic       s2_upd;
  logic       s2_zero;
  dir_t       s2_mdir;
  logic [7:0] s2_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_status <= status1;
      s2_upd    <= upd1;
      s2_zero   <= zero1;
      s2_mdir   <= moving_dir;
      s2_level  <= speed_level_next;
    end
  end

  logic signed [8:0] span;
  logic              span_neg;
  logic [7:0]        span_mag;
  logic [7:0]        s2_lvl_m1;
  logic [15:0]       prod2;

  always_comb begin
    span      = $signed({1'b0, max_drive}) - $signed({1'b0, min_drive});
    span_neg  = span[8];
    span_mag  = span_neg ? 8'(-span) : span[7:0];
    s2_lvl_m1 = s2_level - 8'd1;
    prod2     = {8'd0, s2_lvl_m1} * {8'd0, span_mag};
  end

  // stage 3: divide the product by the level span
  status_t     s3_status;
  logic        s3_upd;
  logic        s3_zero;
  dir_t        s3_mdir;
  logic [7:0]  s3_level;
  logic        s3_neg;
  logic [15:0] s3_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_status <= s2_status;
      s3_upd    <= s2_upd;
      s3_zero   <= s2_zero;
      s3_mdir   <= s2_mdir;
      s3_level  <= s2_level;
      s3_neg    <= span_neg;
      s3_prod   <= prod2;
    end
  end

  logic [40:0] recip_prod;
  logic [7:0]  quot;

  always_comb begin
    recip_prod = {25'd0, s3_prod} * {16'd0, RECIP};
    quot       = recip_prod[SHIFT+7:SHIFT];
  end

  // stage 4: add min_drive, apply signs, output register
  logic signed [8:0] held_left, held_left_next;
  logic signed [8:0] held_right, held_right_next;
  logic signed [8:0] drv;
  status_t           out_status;
  logic [7:0]        out_level;

  always_comb begin
    drv = s3_neg ? $signed({1'b0, min_drive}) - $signed({1'b0, quot})
                 : $signed({1'b0, min_drive}) + $signed({1'b0, quot});
    held_left_next  = held_left;
    held_right_next = held_right;
    if (s3_upd) begin
      if (s3_zero) begin
        held_left_next  = 9'sd0;
        held_right_next = 9'sd0;
      end else begin
        case (s3_mdir)
          DIR_FWD: begin
            held_left_next  = drv;
            held_right_next = drv;
          end
          DIR_BACK: begin
            held_left_next  = -drv;
            held_right_next = -drv;
          end
          DIR_LEFT: begin
            held_left_next  = -drv;
            held_right_next = drv;
          end
          DIR_RIGHT: begin
            held_left_next  = drv;
            held_right_next = -drv;
          end
          default: begin
            held_left_next  = 9'sd0;
            held_right_next = 9'sd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4         <= 1'b0;
      held_left  <= 9'sd0;
      held_right <= 9'sd0;
    end else if (en4) begin
      v4 <= v3;
      if (v3) begin
        held_left  <= held_left_next;
        held_right <= held_right_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      out_status <= s3_status;
      out_level  <= s3_level;
    end
  end

  assign m_tdata = {3'd0, out_level, held_right, held_left, out_status};

endmodule
